### rtl/msd_pkg.sv
// msd_pkg: shared constants, payload structs and sequencer states of the descending merge sorter.
// No dependencies; compile first.
package msd_pkg;

	localparam int MSD_MAX_KEYS   = 64;
	localparam int MSD_KEY_BITS   = 32;
	localparam int MSD_RUN_LENGTH = 16;
	localparam int MSD_PORT_BITS  = 32;

	typedef struct packed {
		logic [MSD_PORT_BITS-1:0] key;
		logic                     is_last;
	} msd_in_t;

	typedef struct packed {
		logic [MSD_PORT_BITS-1:0] sorted_key;
		logic                     end_of_batch;
		logic                     overflow;
	} msd_out_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_IS_NEXT,
		ST_IS_GETV,
		ST_IS_CMP,
		ST_IS_PUT,
		ST_MG_PASS,
		ST_MG_PAIR,
		ST_MG_RDA,
		ST_MG_RDB,
		ST_MG_WR,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_WAIT
	} msd_state_t;

endpackage

### rtl/msd_stream_if.sv
// msd_stream_if: valid/ready channel carrying one payload struct per transfer.
// Payload type is a parameter; used with the structs of msd_pkg.
interface msd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/merge_sort_descending.sv
// merge_sort_descending: batch sorter, keys out largest first (bottom-up merge sort).
// Depends on msd_pkg and msd_stream_if.
//
//  channel | dir | payload                                  | transfer when
//  keys    | in  | key[31:0], is_last                       | keys.valid & keys.ready
//  sorted  | out | sorted_key[31:0], end_of_batch, overflow | sorted.valid & sorted.ready
//
// Each key that fits is written into mem_a. After the closing key, with n keys held and
//   R = RUN_LENGTH: insertion sort of each run of R keys, then ceil(log2(n/R)) merge
//   passes, then emit, which waits while the sink is not ready.
// Speed is set by the single read port of each key memory: every compare waits on a
// registered read.
// Reset clears the sequencer, key count and drop flag; the memories need no clearing pass.
// keys.ready is high only while loading; a stalled sink holds the output register and the
// sequencer waits on it.
module merge_sort_descending #(
	parameter int MAX_KEYS   = msd_pkg::MSD_MAX_KEYS,
	parameter int KEY_BITS   = msd_pkg::MSD_KEY_BITS,
	parameter int RUN_LENGTH = msd_pkg::MSD_RUN_LENGTH
) (
	input  logic                clk,
	input  logic                arst_n,
	msd_stream_if.sink          keys,
	msd_stream_if.source        sorted
);
	import msd_pkg::*;

	// stored key width: keys arrive on a 32-bit port
	localparam int KW = (KEY_BITS < MSD_PORT_BITS) ? KEY_BITS : MSD_PORT_BITS;
	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);
	// positions: lo + 2*run stays below 5*MAX_KEYS + 2*RUN_LENGTH
	localparam int PW = $clog2(5 * MAX_KEYS + 2 * RUN_LENGTH + 1) + 1;

	// two key memories: A is the load store, B the merge scratch; passes ping-pong
	logic [KW-1:0] mem_a [MAX_KEYS];
	logic [KW-1:0] mem_b [MAX_KEYS];
	logic [KW-1:0] rd_a_q, rd_b_q;

	msd_state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic          dropped_q;
	logic          src_sel_q;          // 1: current sorted data lives in mem_b
	logic [PW-1:0] i_q, j_q, run_lo_q; // insertion sort
	logic [PW-1:0] run_q, lo_q, mid_q, hi_q, a_q, b_q, o_q; // merge
	logic [PW-1:0] k_q;                // emit index
	logic [KW-1:0] v_q, ha_q;
	logic          out_valid_q;
	msd_out_t      out_q;

	// memory port controls
	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en, wr_sel;
	logic [KW-1:0] wr_data;
	logic          in_ready;

	logic [KW-1:0] src_data;
	logic [PW-1:0] n_p, im1, jm1, jp1, run_lo_end, mid_c, hi_c, two_run;
	logic          in_xfer, has_room, take_a, pair_done, last_out;

	assign src_data   = src_sel_q ? rd_b_q : rd_a_q;
	assign n_p        = PW'(count_q);
	assign im1        = i_q - PW'(1);
	assign jm1        = j_q - PW'(1);
	assign jp1        = j_q + PW'(1);
	assign run_lo_end = run_lo_q + PW'(RUN_LENGTH);
	assign two_run    = run_q << 1;
	assign mid_c      = (lo_q + run_q < n_p) ? lo_q + run_q : n_p;
	assign hi_c       = (lo_q + two_run < n_p) ? lo_q + two_run : n_p;
	assign in_xfer    = keys.valid && in_ready;
	assign has_room   = count_q < CW'(MAX_KEYS);
	assign pair_done  = (a_q >= mid_q) && (b_q >= hi_q);
	// ties go to run A, ha_q holds the A head, src_data the B head
	assign take_a     = (a_q < mid_q) && ((b_q >= hi_q) || (ha_q >= src_data));
	assign last_out   = (k_q + PW'(1)) == n_p;

	assign keys.ready     = in_ready;
	assign sorted.valid   = out_valid_q;
	assign sorted.payload = out_q;

	// memories: one write and one registered read each per cycle
	always_ff @(posedge clk) begin
		if (wr_en && !wr_sel) begin
			mem_a[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_a[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_sel) begin
			mem_b[wr_addr] <= wr_data;
		end
		rd_b_q <= mem_b[rd_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_xfer && keys.payload.is_last) state_d = ST_IS_NEXT;
			end
			ST_IS_NEXT: begin
				if (i_q >= n_p) state_d = ST_MG_PASS;
				else if (i_q != run_lo_end) state_d = ST_IS_GETV;
			end
			ST_IS_GETV: state_d = ST_IS_CMP;
			ST_IS_CMP: begin
				if (src_data < v_q) begin
					if (j_q == run_lo_q) state_d = ST_IS_PUT;
				end else begin
					state_d = ST_IS_NEXT;
				end
			end
			ST_IS_PUT: state_d = ST_IS_NEXT;
			ST_MG_PASS: begin
				if (run_q >= n_p) state_d = ST_OUT_RD;
				else state_d = ST_MG_PAIR;
			end
			ST_MG_PAIR: begin
				if (lo_q >= n_p) state_d = ST_MG_PASS;
				else state_d = ST_MG_RDA;
			end
			ST_MG_RDA: begin
				if (pair_done) state_d = ST_MG_PAIR;
				else state_d = ST_MG_RDB;
			end
			ST_MG_RDB: state_d = ST_MG_WR;
			ST_MG_WR: state_d = ST_MG_RDA;
			ST_OUT_RD: state_d = ST_OUT_LD;
			ST_OUT_LD: state_d = ST_OUT_WAIT;
			ST_OUT_WAIT: begin
				if (sorted.ready) state_d = last_out ? ST_LOAD : ST_OUT_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// memory port and handshake controls
	always_comb begin
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_sel   = src_sel_q;
		wr_addr  = '0;
		wr_data  = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				wr_en    = keys.valid && has_room;
				wr_sel   = 1'b0;
				wr_addr  = count_q[AW-1:0];
				wr_data  = keys.payload.key[KW-1:0];
			end
			ST_IS_NEXT: rd_addr = i_q[AW-1:0];
			ST_IS_GETV: rd_addr = im1[AW-1:0];
			ST_IS_CMP: begin
				wr_en   = 1'b1;
				wr_addr = jp1[AW-1:0];
				if (src_data < v_q) begin
					// shift the smaller key up, fetch the next one down
					wr_data = src_data;
					rd_addr = jm1[AW-1:0];
				end else begin
					wr_data = v_q;
				end
			end
			ST_IS_PUT: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
				wr_data = v_q;
			end
			ST_MG_RDA: rd_addr = a_q[AW-1:0];
			ST_MG_RDB: rd_addr = b_q[AW-1:0];
			ST_MG_WR: begin
				wr_en   = 1'b1;
				wr_sel  = !src_sel_q;
				wr_addr = o_q[AW-1:0];
				wr_data = take_a ? ha_q : src_data;
			end
			ST_OUT_RD: rd_addr = k_q[AW-1:0];
			default: ;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			src_sel_q   <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			run_lo_q    <= '0;
			run_q       <= '0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			o_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (has_room) count_q <= count_q + CW'(1);
						else dropped_q <= 1'b1;
						if (keys.payload.is_last) begin
							i_q       <= PW'(1);
							run_lo_q  <= '0;
							src_sel_q <= 1'b0;
						end
					end
				end
				ST_IS_NEXT: begin
					if (i_q >= n_p) begin
						run_q <= PW'(RUN_LENGTH);
					end else if (i_q == run_lo_end) begin
						// first key of a new run needs no insertion
						run_lo_q <= i_q;
						i_q      <= i_q + PW'(1);
					end
				end
				ST_IS_GETV: j_q <= im1;
				ST_IS_CMP: begin
					if (src_data < v_q) begin
						if (j_q != run_lo_q) j_q <= jm1;
					end else begin
						i_q <= i_q + PW'(1);
					end
				end
				ST_IS_PUT: i_q <= i_q + PW'(1);
				ST_MG_PASS: begin
					lo_q <= '0;
					k_q  <= '0;
				end
				ST_MG_PAIR: begin
					if (lo_q >= n_p) begin
						src_sel_q <= !src_sel_q;
						run_q     <= two_run;
					end else begin
						a_q   <= lo_q;
						b_q   <= mid_c;
						mid_q <= mid_c;
						hi_q  <= hi_c;
						o_q   <= lo_q;
					end
				end
				ST_MG_RDA: begin
					if (pair_done) lo_q <= lo_q + two_run;
				end
				ST_MG_WR: begin
					o_q <= o_q + PW'(1);
					if (take_a) a_q <= a_q + PW'(1);
					else b_q <= b_q + PW'(1);
				end
				ST_OUT_LD: out_valid_q <= 1'b1;
				ST_OUT_WAIT: begin
					if (sorted.ready) begin
						out_valid_q <= 1'b0;
						if (last_out) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
							src_sel_q <= 1'b0;
						end else begin
							k_q <= k_q + PW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// data registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IS_GETV) v_q <= src_data;
		if (state_q == ST_MG_RDB) ha_q <= src_data;
		if (state_q == ST_OUT_LD) begin
			out_q.sorted_key   <= MSD_PORT_BITS'(src_data);
			out_q.end_of_batch <= last_out;
			out_q.overflow     <= dropped_q;
		end
	end

endmodule

### rtl/msd_checker.sv
// msd_checker: port-level properties of merge_sort_descending, attached by bind.
// Depends on msd_stream_if ports of the top level.
module msd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        keys_valid,
	input logic        keys_ready,
	input logic        keys_is_last,
	input logic        sorted_valid,
	input logic        sorted_ready,
	input logic [31:0] sorted_key,
	input logic        sorted_end,
	input logic        sorted_ovf
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sorted_valid && !sorted_ready |=> sorted_valid && $stable(sorted_key)
			&& $stable(sorted_end) && $stable(sorted_ovf))
		else $error("stalled result changed");

	// loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(keys_ready && sorted_valid))
		else $error("input ready while a result is shown");

	// the closing key stops further loading
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		keys_valid && keys_ready && keys_is_last |=> !keys_ready)
		else $error("ready after closing key");

	// sorted_valid drops once the final key of a batch is taken
	a_batch_end: assert property (@(posedge clk) disable iff (!arst_n)
		sorted_valid && sorted_ready && sorted_end |=> !sorted_valid)
		else $error("result after end of batch");

endmodule

bind merge_sort_descending msd_checker u_msd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.keys_valid   (keys.valid),
	.keys_ready   (keys.ready),
	.keys_is_last (keys.payload.is_last),
	.sorted_valid (sorted.valid),
	.sorted_ready (sorted.ready),
	.sorted_key   (sorted.payload.sorted_key),
	.sorted_end   (sorted.payload.end_of_batch),
	.sorted_ovf   (sorted.payload.overflow)
);
